// ----- hw/rtl/hmmd_pkg.sv -----
// Shared types and constants for the handheld memory map decoder.
// No dependencies; used by hmmd_decode and the top level.
package hmmd_pkg;

  localparam int unsigned BankBytes  = 4096;
  localparam int unsigned BankOffW   = 12;
  localparam int unsigned OffsetW    = 15;
  localparam int unsigned InTdataW   = 40;
  localparam int unsigned OutTdataW  = 40;

  typedef enum logic [1:0] {
    CMD_RD_BYTE = 2'd0,
    CMD_RD_WORD = 2'd1,
    CMD_WR_BYTE = 2'd2,
    CMD_WR_WORD = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    REG_ROM    = 4'd0,
    REG_VRAM   = 4'd1,
    REG_EXTRAM = 4'd2,
    REG_WRAM0  = 4'd3,
    REG_WRAM1  = 4'd4,
    REG_ECHO0  = 4'd5,
    REG_ECHO1  = 4'd6,
    REG_SPRITE = 4'd7,
    REG_EMPTY  = 4'd8,
    REG_IO     = 4'd9,
    REG_HRAM   = 4'd10,
    REG_IE     = 4'd11
  } region_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BYTE0 = 2'd1,
    ST_BYTE1 = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    region_e              region;
    logic [OffsetW-1:0]   offset;
    logic                 external;
  } decode_t;

endpackage

// ----- hw/rtl/hmmd_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module hmmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/hmmd_decode.sv -----
// Address decoder: bus address to region, offset from base and external flag.
// Depends on hmmd_pkg.
module hmmd_decode (
  input  logic [15:0]       addr_i,
  output hmmd_pkg::decode_t dec_o
);

  logic [15:0]       base;
  hmmd_pkg::region_e region;
  logic [3:0]        nib;

  assign nib = addr_i[15:12];

  always_comb begin
    priority if (nib < 4'h8) begin
      region = hmmd_pkg::REG_ROM;    base = 16'h0000;
    end else if (nib < 4'hA) begin
      region = hmmd_pkg::REG_VRAM;   base = 16'h8000;
    end else if (nib < 4'hC) begin
      region = hmmd_pkg::REG_EXTRAM; base = 16'hA000;
    end else if (nib == 4'hC) begin
      region = hmmd_pkg::REG_WRAM0;  base = 16'hC000;
    end else if (nib == 4'hD) begin
      region = hmmd_pkg::REG_WRAM1;  base = 16'hD000;
    end else if (nib == 4'hE) begin
      region = hmmd_pkg::REG_ECHO0;  base = 16'hE000;
    end else if (addr_i <= 16'hFDFF) begin
      region = hmmd_pkg::REG_ECHO1;  base = 16'hF000;
    end else if (addr_i <= 16'hFE9F) begin
      region = hmmd_pkg::REG_SPRITE; base = 16'hFE00;
    end else if (addr_i < 16'hFF00) begin
      region = hmmd_pkg::REG_EMPTY;  base = 16'hFEA0;
    end else if (addr_i <= 16'hFF7F) begin
      region = hmmd_pkg::REG_IO;     base = 16'hFF00;
    end else if (addr_i < 16'hFFFF) begin
      region = hmmd_pkg::REG_HRAM;   base = 16'hFF80;
    end else begin
      region = hmmd_pkg::REG_IE;     base = 16'hFFFF;
    end
  end

  logic [15:0] diff;
  assign diff = addr_i - base;

  always_comb begin
    dec_o.region   = region;
    dec_o.offset   = diff[hmmd_pkg::OffsetW-1:0];
    dec_o.external = (region == hmmd_pkg::REG_ROM)    || (region == hmmd_pkg::REG_VRAM) ||
                     (region == hmmd_pkg::REG_EXTRAM) || (region == hmmd_pkg::REG_SPRITE) ||
                     (region == hmmd_pkg::REG_IO)     || (region == hmmd_pkg::REG_IE);
  end

endmodule

// ----- hw/rtl/handheld_memory_map_decoder_unit.sv -----
// Handheld memory map decoder, top level: sequencer, work RAM and high RAM.
// Depends on hmmd_pkg, hmmd_decode and hmmd_ram.
// Sequence: accepted item -> BYTE0 -> BYTE1 (word only) -> DONE -> output register.
// A new item is taken only in IDLE, after DONE has loaded the last one; each store has a single
// byte-wide port, so a word item walks its two bytes through it one per cycle.
// Reset: rst_ni async active low clears sequencer, output valid and colour_mode;
// RAM contents are undefined until written, no clearing pass.
module handheld_memory_map_decoder_unit #(
  parameter int unsigned WRAM_BANKS     = 8,
  parameter int unsigned HIGH_RAM_BYTES = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cfg: colour_mode
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [1:0] cmd, [17:2] addr, [33:18] wdata, [36:34] wram_bank, [39:37] zero
  input  logic [hmmd_pkg::InTdataW-1:0]    s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [3:0] region, [18:4] offset, [34:19] rdata, [35] external, [39:36] zero
  output logic [hmmd_pkg::OutTdataW-1:0]   m_axis_tdata_o
);

  localparam int unsigned WramDepth = WRAM_BANKS * hmmd_pkg::BankBytes;
  localparam int unsigned WramAw    = $clog2(WramDepth);
  localparam int unsigned BankW     = $clog2(WRAM_BANKS);
  localparam int unsigned HramAw    = $clog2(HIGH_RAM_BYTES);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic colour_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      colour_mode_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpack and decode; item fields are captured on acceptance
  // ---------------------------------------------------------------------------
  hmmd_pkg::decode_t dec_in;
  hmmd_pkg::decode_t dec_q;
  hmmd_pkg::cmd_e    cmd_q;
  logic [15:0]       wdata_q;
  logic [2:0]        bank_q;

  hmmd_decode u_decode (
    .addr_i (s_axis_tdata_i[17:2]),
    .dec_o  (dec_in)
  );

  hmmd_pkg::state_e state_q, state_d;
  logic             in_accept;

  assign s_axis_tready_o = (state_q == hmmd_pkg::ST_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= hmmd_pkg::cmd_e'(s_axis_tdata_i[1:0]);
      wdata_q <= s_axis_tdata_i[33:18];
      bank_q  <= s_axis_tdata_i[36:34];
      dec_q   <= dec_in;
    end
  end

  logic is_word, is_write, is_wram, is_hram;
  assign is_word  = (cmd_q == hmmd_pkg::CMD_RD_WORD) || (cmd_q == hmmd_pkg::CMD_WR_WORD);
  assign is_write = (cmd_q == hmmd_pkg::CMD_WR_BYTE) || (cmd_q == hmmd_pkg::CMD_WR_WORD);
  assign is_wram  = (dec_q.region == hmmd_pkg::REG_WRAM0) || (dec_q.region == hmmd_pkg::REG_WRAM1) ||
                    (dec_q.region == hmmd_pkg::REG_ECHO0) || (dec_q.region == hmmd_pkg::REG_ECHO1);
  assign is_hram  = (dec_q.region == hmmd_pkg::REG_HRAM);

  // ---------------------------------------------------------------------------
  // Store addressing. Upper half (wram1 / echo1) takes the selected bank in colour
  // mode, bank 0 meaning bank 1, else bank 1; reduced modulo the bank count.
  // ---------------------------------------------------------------------------
  logic              upper;
  logic [3:0]        bank_raw, bank_m1, bank_m2, bank_m3;
  logic [WramAw-1:0] wram_idx0, wram_idx1, wram_addr;
  logic [HramAw-1:0] hram_idx0, hram_idx1, hram_addr;
  logic              second;

  assign upper = (dec_q.region == hmmd_pkg::REG_WRAM1) || (dec_q.region == hmmd_pkg::REG_ECHO1);

  always_comb begin
    if (!upper) begin
      bank_raw = 4'd0;
    end else if (colour_mode_q && (bank_q != 3'd0)) begin
      bank_raw = {1'b0, bank_q};
    end else begin
      bank_raw = 4'd1;
    end
    // at most three subtractions: value below 8, bank count at least 2
    bank_m1 = (bank_raw >= 4'(WRAM_BANKS)) ? bank_raw - 4'(WRAM_BANKS) : bank_raw;
    bank_m2 = (bank_m1  >= 4'(WRAM_BANKS)) ? bank_m1  - 4'(WRAM_BANKS) : bank_m1;
    bank_m3 = (bank_m2  >= 4'(WRAM_BANKS)) ? bank_m2  - 4'(WRAM_BANKS) : bank_m2;
  end

  assign wram_idx0 = {bank_m3[BankW-1:0], dec_q.offset[hmmd_pkg::BankOffW-1:0]};
  assign wram_idx1 = (wram_idx0 == WramAw'(WramDepth - 1)) ? '0 : wram_idx0 + WramAw'(1);
  assign hram_idx0 = dec_q.offset[HramAw-1:0];
  assign hram_idx1 = (hram_idx0 == HramAw'(HIGH_RAM_BYTES - 1)) ? '0 : hram_idx0 + HramAw'(1);

  assign second    = (state_q == hmmd_pkg::ST_BYTE1);
  assign wram_addr = second ? wram_idx1 : wram_idx0;
  assign hram_addr = second ? hram_idx1 : hram_idx0;

  // ---------------------------------------------------------------------------
  // Stores: one byte access per cycle in BYTE0 / BYTE1
  // ---------------------------------------------------------------------------
  logic       access, wram_we, wram_re, hram_we, hram_re;
  logic [7:0] wr_byte, wram_rd, hram_rd, rd_byte;

  assign access  = (state_q == hmmd_pkg::ST_BYTE0) || (state_q == hmmd_pkg::ST_BYTE1);
  assign wram_we = access & is_wram & is_write;
  assign wram_re = access & is_wram & ~is_write;
  assign hram_we = access & is_hram & is_write;
  assign hram_re = access & is_hram & ~is_write;
  assign wr_byte = second ? wdata_q[15:8] : wdata_q[7:0];

  hmmd_ram #(.WIDTH(8), .DEPTH(WramDepth)) u_wram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .re_i    (wram_re),
    .addr_i  (wram_addr),
    .wdata_i (wr_byte),
    .rdata_o (wram_rd)
  );

  hmmd_ram #(.WIDTH(8), .DEPTH(HIGH_RAM_BYTES)) u_hram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .re_i    (hram_re),
    .addr_i  (hram_addr),
    .wdata_i (wr_byte),
    .rdata_o (hram_rd)
  );

  // read data only means something for reads of internal stores; it holds
  // between reads since the read port is only enabled on a read
  always_comb begin
    if (is_write) begin
      rd_byte = 8'd0;
    end else if (is_wram) begin
      rd_byte = wram_rd;
    end else if (is_hram) begin
      rd_byte = hram_rd;
    end else begin
      rd_byte = 8'd0;
    end
  end

  logic [7:0] lo_q;

  always_ff @(posedge clk_i) begin
    if (state_q == hmmd_pkg::ST_BYTE1) begin
      lo_q <= rd_byte;  // first byte of a word read
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_load;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      hmmd_pkg::ST_IDLE: begin
        if (in_accept) state_d = hmmd_pkg::ST_BYTE0;
      end
      hmmd_pkg::ST_BYTE0: begin
        state_d = is_word ? hmmd_pkg::ST_BYTE1 : hmmd_pkg::ST_DONE;
      end
      hmmd_pkg::ST_BYTE1: begin
        state_d = hmmd_pkg::ST_DONE;
      end
      hmmd_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = hmmd_pkg::ST_IDLE;
        end
      end
      default: state_d = hmmd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmmd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds one finished item while the next one is taken in
  // ---------------------------------------------------------------------------
  logic [15:0]       rdata_res;
  hmmd_pkg::decode_t out_dec_q;
  logic [15:0]       out_rdata_q;

  assign rdata_res = is_word ? {rd_byte, lo_q} : {8'd0, rd_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dec_q   <= dec_q;
      out_rdata_q <= rdata_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_dec_q.external, out_rdata_q,
                            out_dec_q.offset, out_dec_q.region};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_word_two_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hmmd_pkg::ST_BYTE0) && is_word |=> (state_q == hmmd_pkg::ST_BYTE1))
    else $error("word item skipped its second byte");

  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((wram_we || wram_re) && (hram_we || hram_re)))
    else $error("both stores accessed in one cycle");

  a_store_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wram_we || wram_re || hram_we || hram_re) |->
      (state_q == hmmd_pkg::ST_BYTE0) || (state_q == hmmd_pkg::ST_BYTE1))
    else $error("store access outside byte states");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == hmmd_pkg::ST_DONE))
    else $error("output loaded outside done state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("pending output overwritten");

endmodule
